@@ rtl/ppghr_pkg.sv @@
// Package for the PPG heart-rate and SpO2 estimator.
// Holds the word types, register indexes and fixed constants; no dependencies.
package ppghr_pkg;

  // Width of the shared divider's dividend and quotient.
  localparam int unsigned DivW = 30;
  // Width of the divider's divisor and remainder.
  localparam int unsigned DivisorW = 32;

  // Configuration register indexes.
  localparam logic [1:0] RegIrDc    = 2'd0;
  localparam logic [1:0] RegRedDc   = 2'd1;
  localparam logic [1:0] RegAmbient = 2'd2;

  // Filter coefficients in Q0.16.
  localparam logic [10:0] LpFeedFwd = 11'd1331;
  localparam logic [15:0] LpFeedBack = 16'd62873;
  localparam logic [12:0] SampleMax = 13'd8191;

  // Milliseconds per minute, rate ceiling and detector reset threshold.
  localparam logic [DivW-1:0] MsPerMinute = 30'd60000;
  localparam logic [7:0] RateMax = 8'd255;
  localparam logic [7:0] FallThrReset = 8'd30;

  // SpO2 curve and limits.
  localparam logic [7:0] RatioKnee = 8'd44;
  localparam logic [6:0] Spo2Offset = 7'd116;
  localparam logic [6:0] Spo2Max = 7'd99;

  typedef struct packed {
    logic [12:0] ir_sample;
    logic [12:0] red_sample;
    logic [31:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic [12:0] ir_filtered;
    logic [12:0] red_filtered;
    logic [7:0]  heart_rate;
    logic        ir_beat;
    logic        red_beat;
    logic [6:0]  spo2_value;
    logic        spo2_updated;
  } out_word_t;

endpackage

@@ rtl/ppghr_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ppghr_pkg for the operand widths.
module ppghr_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ppghr_pkg::DivW-1:0]      dividend_i,
  input  logic [ppghr_pkg::DivisorW-1:0]  divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [ppghr_pkg::DivW-1:0]      quotient_o
);
  import ppghr_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivisorW:0]   trial;
  logic                fits;

  // One shift-subtract step.
  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DivisorW'(trial - {1'b0, dvs_q}) : DivisorW'(trial);
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  // A finished division leaves the unit idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  // A start while busy would be lost; the sequencer never does that.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider started while busy");
  // The step counter is only nonzero during a division.
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("divider counter stray");
`endif

endmodule

@@ rtl/ppg_heart_rate_spo2_estimator.sv @@
// Top level of the PPG heart-rate and SpO2 estimator.
// Depends on ppghr_pkg and ppghr_divider.
//
// Each input word holds one IR and one red sample and a millisecond time stamp; it yields
// one output word. The block works on one word at a time under a small sequencer that
// shares a single 30-step restoring divider for the beat rates, the slope ratio and the
// window mean; the group mean uses a reciprocal multiplication. A word takes the shortest
// path when the IR slope is flat, a longer one when the ratio needs no division, and the
// longest when a beat is found on both channels, the ratio is divided and a window and a
// group close. Each of those four divisions holds the sequencer until the divider is done.
// The sequencer also waits in its output state while an earlier finished word still waits
// for out_ready_i. A finished output word waits in its register while the next input word
// is taken. Configuration writes take effect at once; the user must make them only while
// the block is idle, as the block itself does not enforce it.
module ppg_heart_rate_spo2_estimator #(
  parameter int unsigned WINDOW_SAMPLES = 20,
  parameter int unsigned GROUP_WINDOWS  = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [9:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ppghr_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ppghr_pkg::out_word_t  out_word_o
);
  import ppghr_pkg::*;

  localparam int unsigned WsumW = $clog2(WINDOW_SAMPLES * 1050 + 1);
  localparam int unsigned WtotW = $clog2(WINDOW_SAMPLES * 10 + 1);
  localparam int unsigned WcntW = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned GsumW = $clog2(GROUP_WINDOWS * 105 + 1);
  localparam int unsigned GcntW = $clog2(GROUP_WINDOWS + 1);

  // Reciprocal of the group length, exact for every group sum that can occur.
  localparam int unsigned GrpShift = GsumW + $clog2(GROUP_WINDOWS);
  localparam int unsigned RecipW   = GrpShift + 1;
  localparam int unsigned GrpRecip = ((1 << GrpShift) + GROUP_WINDOWS - 1) / GROUP_WINDOWS;

  // Sequencer states.
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StFilt   = 4'd1;
  localparam logic [3:0] StDet    = 4'd2;
  localparam logic [3:0] StRate   = 4'd3;
  localparam logic [3:0] StAvg    = 4'd4;
  localparam logic [3:0] StMul1   = 4'd5;
  localparam logic [3:0] StMul2   = 4'd6;
  localparam logic [3:0] StRStart = 4'd7;
  localparam logic [3:0] StRDiv   = 4'd8;
  localparam logic [3:0] StSpo2   = 4'd9;
  localparam logic [3:0] StMean   = 4'd10;
  localparam logic [3:0] StGrp    = 4'd12;
  localparam logic [3:0] StOut    = 4'd13;

  // Channel select: red is handled first, as the detector order requires.
  localparam logic ChRed = 1'b0;
  localparam logic ChIr  = 1'b1;

  logic [3:0]  state_q, state_d;
  logic        ch_q, ch_d;
  in_word_t    in_q, in_d;
  logic [9:0]  ir_dc_q, red_dc_q, amb_q;

  logic [12:0] raw_prev_q [2];
  logic [12:0] raw_prev_d [2];
  logic [12:0] filt_prev_q [2];
  logic [12:0] filt_prev_d [2];
  logic [12:0] filt_cur_q [2];
  logic [12:0] filt_cur_d [2];
  logic [12:0] slope_abs_q [2];
  logic [12:0] slope_abs_d [2];
  logic [7:0]  fall_cnt_q [2];
  logic [7:0]  fall_cnt_d [2];
  logic [7:0]  fall_thr_q [2];
  logic [7:0]  fall_thr_d [2];
  logic [31:0] last_beat_q [2];
  logic [31:0] last_beat_d [2];
  logic [7:0]  rate_q [2];
  logic [7:0]  rate_d [2];
  logic [1:0]  beat_q, beat_d;

  logic        ir_slope_nz_q, ir_slope_nz_d;
  logic [7:0]  rate_avg_q, rate_avg_d;
  logic [22:0] prod_q, prod_d;
  logic [29:0] num_q, num_d;
  logic [22:0] den_q, den_d;
  logic [7:0]  ratio_q, ratio_d;
  logic [WsumW-1:0] wsum_q, wsum_d;
  logic [WtotW-1:0] wtot_q, wtot_d;
  logic [WcntW-1:0] wcnt_q, wcnt_d;
  logic [GsumW-1:0] gsum_q, gsum_d;
  logic [GcntW-1:0] gcnt_q, gcnt_d;
  logic [6:0]  spo2_level_q, spo2_level_d;
  logic        updated_q, updated_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;

  // Divider hookup.
  logic                div_start;
  logic [DivW-1:0]     div_a;
  logic [DivisorW-1:0] div_b;
  logic                div_busy, div_done;
  logic [DivW-1:0]     div_q;

  // Per-cycle helpers.
  logic [12:0] x_cur;
  logic [31:0] lp_acc;
  logic [12:0] lp_y;
  logic [13:0] slope;
  logic [31:0] interval;
  logic [23:0] thr_prod;
  logic [9:0]  ir_dcd, red_dcd;
  logic [6:0]  spo2_i, spo2_dist;
  logic [3:0]  weight;
  logic [6:0]  mean_v;
  logic        do_close;
  logic [8:0]  rate_sum, avg_sum;
  logic [GsumW-1:0] gsum_new;
  logic [GcntW-1:0] gcnt_new;
  logic [GsumW+RecipW-1:0] grp_prod;
  logic [6:0]  grp_mean;

  function automatic logic [3:0] weight_of(input logic [6:0] d);
    logic [3:0] w;
    if (d > 7'd30)      w = 4'd1;
    else if (d > 7'd20) w = 4'd5;
    else if (d > 7'd15) w = 4'd6;
    else if (d > 7'd10) w = 4'd7;
    else if (d > 7'd7)  w = 4'd8;
    else if (d > 7'd3)  w = 4'd9;
    else                w = 4'd10;
    return w;
  endfunction

  ppghr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_dc_q  <= 10'd512;
      red_dc_q <= 10'd512;
      amb_q    <= 10'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIrDc:    ir_dc_q  <= cfg_data_i;
        RegRedDc:   red_dc_q <= cfg_data_i;
        RegAmbient: amb_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // DC levels above ambient, clamped at zero.
  assign ir_dcd  = (ir_dc_q > amb_q) ? ir_dc_q - amb_q : 10'd0;
  assign red_dcd = (red_dc_q > amb_q) ? red_dc_q - amb_q : 10'd0;

  // Low-pass filter of the current channel.
  assign x_cur  = (ch_q == ChIr) ? in_q.ir_sample : in_q.red_sample;
  assign lp_acc = 32'(LpFeedFwd * ({1'b0, x_cur} + {1'b0, raw_prev_q[ch_q]}))
                + 32'(LpFeedBack * filt_prev_q[ch_q]);
  assign lp_y   = (lp_acc[31:16] > 16'(SampleMax)) ? SampleMax : lp_acc[28:16];

  // Slope, beat interval and new threshold of the current channel.
  assign slope    = {1'b0, filt_cur_q[ch_q]} - {1'b0, filt_prev_q[ch_q]};
  assign interval = in_q.time_ms - last_beat_q[ch_q];
  // floor(3*count/5) through a reciprocal that is exact for counts up to 255.
  assign thr_prod = 24'(10'(fall_cnt_q[ch_q] * 2'd3) * 15'd13108);

  // Instantaneous SpO2 and its weight; 25*R/100 is R/4.
  assign spo2_i    = (ratio_q > RatioKnee) ? Spo2Offset - 7'(ratio_q >> 2) : Spo2Max;
  assign spo2_dist = (spo2_i > spo2_level_q) ? spo2_i - spo2_level_q : spo2_level_q - spo2_i;
  assign weight    = weight_of(spo2_dist);

  assign rate_sum = {1'b0, rate_q[0]} + {1'b0, rate_q[1]};
  assign avg_sum  = {1'b0, rate_avg_q} + {1'b0, rate_sum[8:1]};

  // Group mean, floor(sum / GROUP_WINDOWS), by the reciprocal.
  assign grp_prod = gsum_q * RecipW'(GrpRecip);
  assign grp_mean = grp_prod[GrpShift +: 7];

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    ch_d          = ch_q;
    in_d          = in_q;
    raw_prev_d    = raw_prev_q;
    filt_prev_d   = filt_prev_q;
    filt_cur_d    = filt_cur_q;
    slope_abs_d   = slope_abs_q;
    fall_cnt_d    = fall_cnt_q;
    fall_thr_d    = fall_thr_q;
    last_beat_d   = last_beat_q;
    rate_d        = rate_q;
    beat_d        = beat_q;
    ir_slope_nz_d = ir_slope_nz_q;
    rate_avg_d    = rate_avg_q;
    prod_d        = prod_q;
    num_d         = num_q;
    den_d         = den_q;
    ratio_d       = ratio_q;
    wsum_d        = wsum_q;
    wtot_d        = wtot_q;
    wcnt_d        = wcnt_q;
    gsum_d        = gsum_q;
    gcnt_d        = gcnt_q;
    spo2_level_d  = spo2_level_q;
    updated_d     = updated_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    div_start     = 1'b0;
    div_a         = '0;
    div_b         = '0;
    mean_v        = '0;
    do_close      = 1'b0;
    gsum_new      = '0;
    gcnt_new      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          in_d      = in_word_i;
          ch_d      = ChRed;
          beat_d    = '0;
          updated_d = 1'b0;
          state_d   = StFilt;
        end
      end
      StFilt: begin
        filt_cur_d[ch_q] = lp_y;
        state_d = StDet;
      end
      StDet: begin
        slope_abs_d[ch_q] = slope[13] ? 13'(-slope) : slope[12:0];
        if (ch_q == ChIr) begin
          ir_slope_nz_d = (slope != '0);
        end
        raw_prev_d[ch_q]  = x_cur;
        filt_prev_d[ch_q] = filt_cur_q[ch_q];
        state_d = (ch_q == ChRed) ? StFilt : StAvg;
        ch_d    = ChIr;
        if (slope[13]) begin
          if (fall_cnt_q[ch_q] != RateMax) begin
            fall_cnt_d[ch_q] = fall_cnt_q[ch_q] + 1'b1;
          end
        end else begin
          fall_cnt_d[ch_q] = '0;
          if (fall_cnt_q[ch_q] >= fall_thr_q[ch_q]) begin
            beat_d[ch_q]      = 1'b1;
            fall_thr_d[ch_q]  = thr_prod[23:16];
            last_beat_d[ch_q] = in_q.time_ms;
            if (interval == '0) begin
              rate_d[ch_q] = RateMax;
            end else begin
              div_start = 1'b1;
              div_a     = MsPerMinute;
              div_b     = interval;
              ch_d      = ch_q;
              state_d   = StRate;
            end
          end
        end
      end
      StRate: begin
        if (div_done) begin
          rate_d[ch_q] = (div_q > DivW'(RateMax)) ? RateMax : div_q[7:0];
          state_d = (ch_q == ChRed) ? StFilt : StAvg;
          ch_d    = ChIr;
        end
      end
      StAvg: begin
        rate_avg_d = avg_sum[8:1];
        state_d    = ir_slope_nz_q ? StMul1 : StOut;
      end
      StMul1: begin
        prod_d  = slope_abs_q[ChRed] * ir_dcd;
        state_d = StMul2;
      end
      StMul2: begin
        num_d   = 30'(prod_q * 7'd100);
        den_d   = slope_abs_q[ChIr] * red_dcd;
        state_d = StRStart;
      end
      StRStart: begin
        if (den_q == '0) begin
          ratio_d = RateMax;
          state_d = StSpo2;
        end else begin
          div_start = 1'b1;
          div_a     = num_q;
          div_b     = DivisorW'(den_q);
          state_d   = StRDiv;
        end
      end
      StRDiv: begin
        if (div_done) begin
          ratio_d = (div_q > DivW'(RateMax)) ? RateMax : div_q[7:0];
          state_d = StSpo2;
        end
      end
      StSpo2: begin
        if (wcnt_q < WcntW'(WINDOW_SAMPLES)) begin
          wsum_d  = wsum_q + WsumW'(spo2_i * weight);
          wtot_d  = wtot_q + WtotW'(weight);
          wcnt_d  = wcnt_q + 1'b1;
          state_d = StOut;
        end else if (wtot_q != '0) begin
          div_start = 1'b1;
          div_a     = DivW'(wsum_q);
          div_b     = DivisorW'(wtot_q);
          state_d   = StMean;
        end else begin
          do_close = 1'b1;
        end
      end
      StMean: begin
        if (div_done) begin
          mean_v   = div_q[6:0];
          do_close = 1'b1;
        end
      end
      StGrp: begin
        spo2_level_d = (grp_mean > Spo2Max) ? Spo2Max : grp_mean;
        gsum_d       = '0;
        gcnt_d       = '0;
        updated_d    = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.ir_filtered  = filt_cur_q[ChIr];
          out_d.red_filtered = filt_cur_q[ChRed];
          out_d.heart_rate   = rate_avg_q;
          out_d.ir_beat      = beat_q[ChIr];
          out_d.red_beat     = beat_q[ChRed];
          out_d.spo2_value   = spo2_level_q;
          out_d.spo2_updated = updated_q;
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // Window close: fold the mean into the group.
    if (do_close) begin
      gsum_new = gsum_q + GsumW'(mean_v);
      gcnt_new = gcnt_q + 1'b1;
      gsum_d   = gsum_new;
      gcnt_d   = gcnt_new;
      wsum_d   = '0;
      wtot_d   = '0;
      wcnt_d   = '0;
      state_d  = (gcnt_new >= GcntW'(GROUP_WINDOWS)) ? StGrp : StOut;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      ch_q          <= ChRed;
      raw_prev_q    <= '{default: '0};
      filt_prev_q   <= '{default: '0};
      fall_cnt_q    <= '{default: '0};
      fall_thr_q    <= '{default: FallThrReset};
      last_beat_q   <= '{default: '0};
      rate_q        <= '{default: '0};
      rate_avg_q    <= '0;
      wsum_q        <= '0;
      wtot_q        <= '0;
      wcnt_q        <= '0;
      gsum_q        <= '0;
      gcnt_q        <= '0;
      spo2_level_q  <= Spo2Max;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ch_q          <= ch_d;
      raw_prev_q    <= raw_prev_d;
      filt_prev_q   <= filt_prev_d;
      fall_cnt_q    <= fall_cnt_d;
      fall_thr_q    <= fall_thr_d;
      last_beat_q   <= last_beat_d;
      rate_q        <= rate_d;
      rate_avg_q    <= rate_avg_d;
      wsum_q        <= wsum_d;
      wtot_q        <= wtot_d;
      wcnt_q        <= wcnt_d;
      gsum_q        <= gsum_d;
      gcnt_q        <= gcnt_d;
      spo2_level_q  <= spo2_level_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    in_q          <= in_d;
    filt_cur_q    <= filt_cur_d;
    slope_abs_q   <= slope_abs_d;
    beat_q        <= beat_d;
    ir_slope_nz_q <= ir_slope_nz_d;
    prod_q        <= prod_d;
    num_q         <= num_d;
    den_q         <= den_d;
    ratio_q       <= ratio_d;
    updated_q     <= updated_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // The averaged SpO2 never leaves its cap.
  a_spo2_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spo2_level_q <= Spo2Max) else $error("SpO2 average above cap");
  // The divider is idle whenever a new word may enter.
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !div_busy) else $error("divider busy while idle");
  // The window fill never passes its length.
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WcntW'(WINDOW_SAMPLES)) else $error("window overfilled");
  // A new output word is loaded only from the output state.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut) else $error("stray output word");
`endif

endmodule

@@ sim/tb_ppg_heart_rate_spo2_estimator.sv @@
// Testbench for the PPG heart-rate and SpO2 estimator: drives sample words and register
// writes, predicts every output word and compares them field by field.
// Depends on ppghr_pkg and the ppg_heart_rate_spo2_estimator RTL.
`timescale 1ns / 1ps

module tb_ppg_heart_rate_spo2_estimator;
  import ppghr_pkg::*;

  localparam int WinSamples = 20;
  localparam int GroupWins  = 10;
  localparam int WatchLimit = 20000;

  // Idle modes for the sender and the receiver.
  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegIrDc;
  logic [9:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_word_t   in_word_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_word_t  out_word_o;

  ppg_heart_rate_spo2_estimator dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state, one copy per channel where the block has two.
  int unsigned raw_prev[2], filt_prev[2], fall_cnt[2], fall_thr[2], beat_time[2], chan_rate[2];
  int unsigned ir_dc, red_dc, ambient;
  int unsigned hr_avg, wsum, wtot, win_cnt, grp_sum, grp_cnt, spo2_level;

  out_word_t expected_words[$];
  int errors = 0;
  int words_in = 0, words_out = 0, beats_seen = 0, spo2_updates = 0;
  int idle_cycles = 0;
  idle_mode_e idle_mode = IdleNone;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at word %0d: %s got %0d expected %0d", words_out, what, got, want);
    errors++;
  endtask

  function automatic int unsigned lowpass(int unsigned x, int unsigned xp, int unsigned yp);
    int unsigned y;
    y = (1331 * (x + xp) + 62873 * yp) >> 16;
    return (y > 8191) ? 8191 : y;
  endfunction

  // Mountaineer detector on one channel; returns the signed slope.
  function automatic int detect_beat(int ch, int unsigned filt, int unsigned t, output bit beat);
    int slope;
    int unsigned iv, r;
    slope = int'(filt) - int'(filt_prev[ch]);
    beat = 1'b0;
    if (slope < 0) begin
      if (fall_cnt[ch] < 255) fall_cnt[ch]++;
    end else begin
      if (fall_cnt[ch] >= fall_thr[ch]) begin
        iv = t - beat_time[ch];
        r = (iv == 0) ? 255 : 60000 / iv;
        fall_thr[ch] = (fall_cnt[ch] * 3) / 5;
        chan_rate[ch] = (r > 255) ? 255 : r;
        beat_time[ch] = t;
        beat = 1'b1;
      end
      fall_cnt[ch] = 0;
    end
    return slope;
  endfunction

  function automatic int unsigned spo2_weight(int unsigned d);
    if (d > 30) return 1;
    if (d > 20) return 5;
    if (d > 15) return 6;
    if (d > 10) return 7;
    if (d > 7) return 8;
    if (d > 3) return 9;
    return 10;
  endfunction

  function automatic void reset_estimate();
    for (int c = 0; c < 2; c++) begin
      raw_prev[c] = 0; filt_prev[c] = 0; fall_cnt[c] = 0;
      fall_thr[c] = 30; beat_time[c] = 0; chan_rate[c] = 0;
    end
    ir_dc = 512; red_dc = 512; ambient = 0;
    hr_avg = 0; wsum = 0; wtot = 0; win_cnt = 0; grp_sum = 0; grp_cnt = 0; spo2_level = 99;
  endfunction

  // Works out the output word for one sample word and advances the state.
  function automatic out_word_t estimate_word(in_word_t w);
    out_word_t o;
    int unsigned irf, rdf, ratio, sp, d, wt, mean, a;
    longint unsigned asr, asi, ird, rdd, num, den, q;
    int sr, si;
    bit rb, ib, upd;
    upd = 1'b0;
    irf = lowpass(w.ir_sample, raw_prev[0], filt_prev[0]);
    rdf = lowpass(w.red_sample, raw_prev[1], filt_prev[1]);
    sr = detect_beat(1, rdf, w.time_ms, rb);
    si = detect_beat(0, irf, w.time_ms, ib);
    hr_avg = (hr_avg + (chan_rate[0] + chan_rate[1]) / 2) / 2;
    if (si != 0) begin
      asr = (sr < 0) ? -sr : sr;
      asi = (si < 0) ? -si : si;
      ird = (ir_dc > ambient) ? ir_dc - ambient : 0;
      rdd = (red_dc > ambient) ? red_dc - ambient : 0;
      num = 100 * asr * ird;
      den = asi * rdd;
      if (den == 0) ratio = 255;
      else begin
        q = num / den;
        ratio = (q > 255) ? 255 : int'(q);
      end
      sp = (ratio > 44) ? 116 - (25 * ratio) / 100 : 99;
      d = (sp > spo2_level) ? sp - spo2_level : spo2_level - sp;
      if (win_cnt < WinSamples) begin
        wt = spo2_weight(d);
        wsum += sp * wt;
        wtot += wt;
        win_cnt++;
      end else begin
        mean = (wtot != 0) ? wsum / wtot : 0;
        grp_sum += mean;
        grp_cnt++;
        wsum = 0; wtot = 0; win_cnt = 0;
        if (grp_cnt >= GroupWins) begin
          a = grp_sum / GroupWins;
          spo2_level = (a > 99) ? 99 : a;
          grp_sum = 0; grp_cnt = 0;
          upd = 1'b1;
        end
      end
    end
    raw_prev[0] = w.ir_sample; raw_prev[1] = w.red_sample;
    filt_prev[0] = irf; filt_prev[1] = rdf;
    o.ir_filtered = irf[12:0];
    o.red_filtered = rdf[12:0];
    o.heart_rate = hr_avg[7:0];
    o.ir_beat = ib;
    o.red_beat = rb;
    o.spo2_value = spo2_level[6:0];
    o.spo2_updated = upd;
    return o;
  endfunction

  function automatic bit idle_now(bit is_send);
    case (idle_mode)
      IdleSend: return is_send && ($urandom_range(99) < 71);
      IdleRecv: return !is_send && ($urandom_range(99) < 71);
      IdleBoth: return $urandom_range(99) < 11;
      default:  return 1'b0;
    endcase
  endfunction

  // Receiver: stalls at random, checks each accepted word against the oldest prediction.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !idle_now(1'b0);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        report("unexpected output word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.ir_filtered !== want.ir_filtered)
          report("ir_filtered", out_word_o.ir_filtered, want.ir_filtered);
        if (out_word_o.red_filtered !== want.red_filtered)
          report("red_filtered", out_word_o.red_filtered, want.red_filtered);
        if (out_word_o.heart_rate !== want.heart_rate)
          report("heart_rate", out_word_o.heart_rate, want.heart_rate);
        if (out_word_o.ir_beat !== want.ir_beat)
          report("ir_beat", out_word_o.ir_beat, want.ir_beat);
        if (out_word_o.red_beat !== want.red_beat)
          report("red_beat", out_word_o.red_beat, want.red_beat);
        if (out_word_o.spo2_value !== want.spo2_value)
          report("spo2_value", out_word_o.spo2_value, want.spo2_value);
        if (out_word_o.spo2_updated !== want.spo2_updated)
          report("spo2_updated", out_word_o.spo2_updated, want.spo2_updated);
        beats_seen += want.ir_beat + want.red_beat;
        spo2_updates += want.spo2_updated;
      end
      words_out++;
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("FAIL ppg_heart_rate_spo2_estimator");
      $finish;
    end
  end

  // Sends one sample word and records its prediction at the accepting edge. Valid is
  // dropped only when the sender idles or stops, so it never gets two updates at once.
  task automatic send_word(input in_word_t w, input bit has_want, input out_word_t want);
    out_word_t pred;
    while (idle_now(1'b1)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = estimate_word(w);
    if (has_want && pred !== want) begin
      $display("directed row %0d: predictor disagrees with typed value", words_in);
      errors++;
    end
    expected_words.push_back(pred);
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (160) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[9:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegIrDc:  ir_dc = val;
      RegRedDc: red_dc = val;
      default:  ambient = val;
    endcase
  endtask

  // Directed rows: ir, red, time, whether the result is typed in, typed result.
  typedef struct {
    int unsigned ir, red, t;
    bit has_want;
    out_word_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // A pulse train: falls for fall_len samples then rises, with random content.
  task automatic send_pulses(int n, int fall_len, int unsigned step_ms, int unsigned amp);
    int unsigned t, lvl;
    in_word_t w;
    t = $urandom;
    lvl = $urandom_range(8191 - amp, 2000);
    for (int i = 0; i < n; i++) begin
      if ((i % (fall_len + 4)) < fall_len) lvl = (lvl > amp) ? lvl - $urandom_range(amp, 1) : 0;
      else lvl = (lvl + 3 * amp < 8191) ? lvl + $urandom_range(3 * amp, amp) : 8191;
      t += step_ms;
      w.ir_sample = lvl[12:0];
      w.red_sample = 13'((lvl * $urandom_range(12, 6)) / 10 > 8191 ? 8191 :
                         (lvl * $urandom_range(12, 6)) / 10);
      w.time_ms = ($urandom_range(99) < 3) ? $urandom : t;
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    in_word_t w;
    out_word_t z;
    reset_estimate();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // After reset a zero word stays zero, with default average and no beat.
    z = '0; z.spo2_value = Spo2Max;
    dir_rows.push_back('{0, 0, 0, 1'b1, z});
    // Full-scale steps: filter rises, then long falls, zero interval and tiny runs.
    dir_rows.push_back('{8191, 8191, 32'hFFFF_FFFF, 1'b0, '0});
    dir_rows.push_back('{8191, 0, 0, 1'b0, '0});
    for (int i = 0; i < 12; i++) dir_rows.push_back('{0, 8191 - i * 600, 100 + i, 1'b0, '0});
    dir_rows.push_back('{8191, 8191, 111, 1'b0, '0});
    dir_rows.push_back('{8191, 8191, 111, 1'b0, '0});
    dir_rows.push_back('{0, 0, 500, 1'b0, '0});
    dir_rows.push_back('{4096, 0, 501, 1'b0, '0});
    dir_rows.push_back('{5461, 2730, 1500, 1'b0, '0});
    dir_rows.push_back('{1, 8190, 1501, 1'b0, '0});
    foreach (dir_rows[i]) begin
      w.ir_sample = dir_rows[i].ir[12:0];
      w.red_sample = dir_rows[i].red[12:0];
      w.time_ms = dir_rows[i].t;
      send_word(w, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Register extremes, then random settings, each phase with the idle mode given by its index modulo four.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(RegIrDc, 1023); write_reg(RegRedDc, 1023); write_reg(RegAmbient, 0); end
        1: begin write_reg(RegIrDc, 0); write_reg(RegRedDc, 300); write_reg(RegAmbient, 1023); end
        2: begin write_reg(RegIrDc, 600); write_reg(RegRedDc, 100); write_reg(RegAmbient, 200); end
        default: begin
          write_reg(RegIrDc, $urandom_range(1023));
          write_reg(RegRedDc, $urandom_range(1023));
          write_reg(RegAmbient, $urandom_range(300));
        end
      endcase
      idle_mode = idle_mode_e'(ph % 4);
      send_pulses(200, $urandom_range(40, 2), $urandom_range(20, 0), $urandom_range(400, 1));
      for (int i = 0; i < 40; i++) begin
        w.ir_sample = 13'($urandom); w.red_sample = 13'($urandom); w.time_ms = $urandom;
        send_word(w, 1'b0, '0);
      end
    end

    idle_mode = IdleNone;
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("sent %0d words, checked %0d, %0d beats, %0d SpO2 renewals, %0d errors",
             words_in, words_out, beats_seen, spo2_updates, errors);
    if (errors == 0 && expected_words.size() == 0)
      $display("PASS ppg_heart_rate_spo2_estimator");
    else
      $display("FAIL ppg_heart_rate_spo2_estimator");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ppghr_pkg.sv
rtl/ppghr_divider.sv
rtl/ppg_heart_rate_spo2_estimator.sv
sim/tb_ppg_heart_rate_spo2_estimator.sv
